[sv/msep_pkg.sv]
// package for the midi stream event parser: event kind codes, status constants,
// the result record and the decode helper functions
// no dependencies
package msep_pkg;

  typedef enum logic [3:0] {
    KIND_NOTEOFF   = 4'd0,
    KIND_NOTEON    = 4'd1,
    KIND_POLYPRESS = 4'd2,
    KIND_CONTROL   = 4'd3,
    KIND_PROGRAM   = 4'd4,
    KIND_CHANPRESS = 4'd5,
    KIND_WHEEL     = 4'd6,
    KIND_SONGPOS   = 4'd7,
    KIND_SONGSEL   = 4'd8,
    KIND_REALTIME  = 4'd9,
    KIND_NOSTATUS  = 4'd10,
    KIND_SYSEX     = 4'd11
  } kind_t;

  localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
  localparam logic [7:0] STATUS_SONGPOS = 8'hF2;
  localparam logic [7:0] STATUS_SONGSEL = 8'hF3;
  localparam logic [3:0] HI_SYSTEM      = 4'hF;
  localparam logic [3:0] HI_NOTEON      = 4'h9;
  localparam logic [3:0] HI_PROGRAM     = 4'hC;
  localparam logic [3:0] HI_CHANPRESS   = 4'hD;
  localparam logic [7:0] VEL_DEFAULT    = 8'h40;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] channel;
    logic [7:0] first_value;
    logic [7:0] second_value;
  } event_t;

  // data bytes that follow a status byte
  function automatic logic [1:0] data_count(input logic [7:0] status);
    logic [1:0] n;
    begin
      unique case (status[7:4])
        HI_PROGRAM, HI_CHANPRESS: n = 2'd1;
        HI_SYSTEM: begin
          if (status == STATUS_SONGPOS) n = 2'd2;
          else if (status == STATUS_SONGSEL) n = 2'd1;
          else n = 2'd0;
        end
        default: n = 2'd2;
      endcase
      return n;
    end
  endfunction

  // completed message for status st with data a and b
  function automatic event_t emit_message(input logic [7:0] st, input logic [7:0] a,
                                          input logic [7:0] b);
    event_t ev;
    begin
      ev.first_value  = a;
      ev.second_value = b;
      ev.channel      = st[3:0];
      ev.kind         = kind_t'({1'b0, st[6:4]});
      if (st[7:4] == HI_SYSTEM) begin
        ev.channel = 4'd0;
        if (st == STATUS_SONGPOS) begin
          ev.kind = KIND_SONGPOS;
        end else begin
          ev.kind         = KIND_SONGSEL;
          ev.second_value = 8'd0;
        end
      end else if (st[7:4] == HI_NOTEON && b == 8'd0) begin
        // note-on with zero velocity reads as note-off
        ev.kind         = KIND_NOTEOFF;
        ev.second_value = VEL_DEFAULT;
      end
      return ev;
    end
  endfunction

endpackage

[sv/msep_byte_if.sv]
// byte stream channel of the midi stream event parser: valid/ready and one byte
// no dependencies
interface msep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

[sv/msep_event_if.sv]
// decoded event channel of the midi stream event parser: valid/ready and event fields
// no dependencies
interface msep_event_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_kind;
  logic [3:0] channel;
  logic [7:0] first_value;
  logic [7:0] second_value;

  modport source (output valid, output event_kind, output channel, output first_value,
                  output second_value, input ready);
  modport sink (input valid, input event_kind, input channel, input first_value,
                input second_value, output ready);
endinterface

[sv/midi_stream_event_parser_unit.sv]
// midi byte stream parser with running status: one byte in, at most one event out
// an event appears on the output register in the cycle after its last byte is taken
// throughput: one byte per cycle; parser state and the result register update together
// a held result only stalls input when it is not taken in the same cycle
// reset (synchronous, rst high) clears running status, pending count and output valid
// depends on msep_pkg, msep_byte_if, msep_event_if
module midi_stream_event_parser_unit (
  input logic          clk,
  input logic          rst,
  msep_byte_if.sink    stream,
  msep_event_if.source events
);
  import msep_pkg::*;

  logic [7:0] running_status, running_status_next;
  logic [7:0] message_status, message_status_next;
  logic [7:0] held_data, held_data_next;
  logic [1:0] bytes_pending, bytes_pending_next;
  logic       take;
  logic       ev_valid;
  event_t     ev;
  logic       out_valid;
  event_t     out_ev;
  logic [7:0] b;

  assign b    = stream.stream_byte;
  assign take = stream.valid && stream.ready;
  assign stream.ready = !out_valid || events.ready;

  always_comb begin
    running_status_next = running_status;
    message_status_next = message_status;
    held_data_next      = held_data;
    bytes_pending_next  = bytes_pending;
    ev_valid            = 1'b0;
    ev                  = '{kind: KIND_NOTEOFF, channel: 4'd0, first_value: b,
                            second_value: 8'd0};
    if (bytes_pending == 2'd1) begin
      bytes_pending_next = 2'd0;
      ev_valid           = 1'b1;
      if (data_count(message_status) == 2'd2) ev = emit_message(message_status, held_data, b);
      else ev = emit_message(message_status, b, 8'd0);
    end else if (bytes_pending != 2'd0) begin
      // status-like bytes are taken as data here
      held_data_next     = b;
      bytes_pending_next = 2'd1;
    end else if (b[7]) begin
      if (b[7:4] != HI_SYSTEM) running_status_next = b;
      if (b == STATUS_SYSEX) begin
        ev_valid = 1'b1;
        ev.kind  = KIND_SYSEX;
      end else if (data_count(b) == 2'd0) begin
        ev_valid = 1'b1;
        ev.kind  = KIND_REALTIME;
      end else begin
        message_status_next = b;
        bytes_pending_next  = data_count(b);
      end
    end else if (!running_status[7]) begin
      ev_valid = 1'b1;
      ev.kind  = KIND_NOSTATUS;
    end else begin
      message_status_next = running_status;
      if (data_count(running_status) == 2'd1) begin
        ev_valid = 1'b1;
        ev       = emit_message(running_status, b, 8'd0);
      end else begin
        held_data_next     = b;
        bytes_pending_next = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status <= 8'd0;
      message_status <= 8'd0;
      held_data      <= 8'd0;
      bytes_pending  <= 2'd0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        running_status <= running_status_next;
        message_status <= message_status_next;
        held_data      <= held_data_next;
        bytes_pending  <= bytes_pending_next;
      end
      if (take && ev_valid) out_valid <= 1'b1;
      else if (events.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ev_valid) out_ev <= ev;
  end

  assign events.valid        = out_valid;
  assign events.event_kind   = out_ev.kind;
  assign events.channel      = out_ev.channel;
  assign events.first_value  = out_ev.first_value;
  assign events.second_value = out_ev.second_value;

  // pending count only ever holds 0, 1 or 2
  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    bytes_pending != 2'd3)
    else $error("pending byte count out of range");

  // running status is empty or a channel status
  a_running_channel: assert property (@(posedge clk) disable iff (rst)
    running_status == 8'd0 || (running_status[7] && running_status[7:4] != HI_SYSTEM))
    else $error("running status holds a non-channel byte");

  // orphan data byte raises the no-status error next cycle
  a_nostatus: assert property (@(posedge clk) disable iff (rst)
    take && bytes_pending == 2'd0 && !b[7] && !running_status[7]
    |=> events.valid && events.event_kind == KIND_NOSTATUS)
    else $error("missing no-status error");

  // first of two data bytes leaves exactly one pending
  a_two_to_one: assert property (@(posedge clk) disable iff (rst)
    take && bytes_pending == 2'd2 |=> bytes_pending == 2'd1)
    else $error("pending count did not step down");

endmodule
